### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the string-to-double core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSTD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSTD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dstd_pkg.sv
// ----------------------------------------------------------------------------
// dstd_pkg
// Types and constants shared by the string-to-double controller and datapath.
// ----------------------------------------------------------------------------
package dstd_pkg;

   typedef enum logic [4:0] {
      DP_IDLE,
      DP_SPECIAL,
      DP_FRAC_INIT,
      DP_FRAC_STEP,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_NORM_ACC,
      DP_NORM_BE,
      DP_ITER_DEC,
      DP_ZINT_SETUP,
      DP_BE_INIT,
      DP_INT_SHIFT,
      DP_ASSEMBLE,
      DP_EXTRA_LOAD,
      DP_TEN_MUL,
      DP_EXP_LOAD,
      DP_ROUND,
      DP_PACK,
      DP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      logic      take;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic need_build;
      logic int_in_range;
      logic int_zero;
      logic int_top;
      logic w_zero;
      logic w_top;
      logic iter_zero;
      logic frac_last;
      logic div_last;
      logic exp_neg;
   } dp_stat_type;

   localparam logic [63:0] TENTH_MAX   = 64'h1999_9999_9999_9999;
   localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] QNAN        = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ROUND_LIMIT = 64'h7FDF_FFFF_FFFF_FFFF;

endpackage

### rtl/dstd_ctrl.sv
// ----------------------------------------------------------------------------
// dstd_ctrl
// Sequencer: character intake, build loop control and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dstd_ctrl import dstd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_is_last,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [4:0] {
      ST_PARSE,
      ST_DECIDE,
      ST_FRAC,
      ST_LZ_CHECK,
      ST_LZ_DIV,
      ST_LZ_NORM,
      ST_AFTER_LZ,
      ST_ZNORM,
      ST_INORM,
      ST_EXTRA_CHECK,
      ST_EXTRA_NORM,
      ST_EXP_LOAD,
      ST_EXP_CHECK,
      ST_EXP_DIV,
      ST_EXP_NORM,
      ST_ROUND,
      ST_PACK,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_PARSE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.take     = 1'b0;
      cmd.op       = DP_IDLE;
      case (state_ff)
         ST_PARSE: begin
            cmd.take = req_valid;
            if (req_valid && req_is_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.need_build) begin
               cmd.op   = DP_SPECIAL;
               state_in = ST_EMIT;
            end else if (stat.int_in_range) begin
               cmd.op   = DP_FRAC_INIT;
               state_in = ST_FRAC;
            end else begin
               cmd.op   = DP_BE_INIT;
               state_in = ST_INORM;
            end
         end
         ST_FRAC: begin
            cmd.op = DP_FRAC_STEP;
            if (stat.frac_last) begin
               state_in = ST_LZ_CHECK;
            end
         end
         ST_LZ_CHECK: begin
            if (stat.iter_zero || stat.w_zero) begin
               state_in = ST_AFTER_LZ;
            end else begin
               cmd.op   = DP_DIV_INIT;
               state_in = ST_LZ_DIV;
            end
         end
         ST_LZ_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (stat.div_last) begin
               state_in = ST_LZ_NORM;
            end
         end
         ST_LZ_NORM: begin
            if (stat.w_zero) begin
               state_in = ST_AFTER_LZ;
            end else if (stat.w_top) begin
               cmd.op   = DP_ITER_DEC;
               state_in = ST_LZ_CHECK;
            end else begin
               cmd.op = DP_NORM_ACC;
            end
         end
         ST_AFTER_LZ: begin
            if (stat.int_zero) begin
               if (stat.w_zero) begin
                  cmd.op   = DP_SPECIAL;
                  state_in = ST_EMIT;
               end else begin
                  cmd.op   = DP_ZINT_SETUP;
                  state_in = ST_ZNORM;
               end
            end else begin
               cmd.op   = DP_BE_INIT;
               state_in = ST_INORM;
            end
         end
         ST_ZNORM: begin
            if (stat.w_top) begin
               state_in = ST_EXP_LOAD;
            end else begin
               cmd.op = DP_NORM_BE;
            end
         end
         ST_INORM: begin
            if (stat.int_top) begin
               if (stat.int_in_range) begin
                  cmd.op   = DP_ASSEMBLE;
                  state_in = ST_EXP_LOAD;
               end else begin
                  cmd.op   = DP_EXTRA_LOAD;
                  state_in = ST_EXTRA_CHECK;
               end
            end else begin
               cmd.op = DP_INT_SHIFT;
            end
         end
         ST_EXTRA_CHECK: begin
            if (stat.iter_zero) begin
               state_in = ST_EXP_LOAD;
            end else begin
               cmd.op   = DP_TEN_MUL;
               state_in = ST_EXTRA_NORM;
            end
         end
         ST_EXTRA_NORM: begin
            if (stat.w_top || stat.w_zero) begin
               cmd.op   = DP_ITER_DEC;
               state_in = ST_EXTRA_CHECK;
            end else begin
               cmd.op = DP_NORM_BE;
            end
         end
         ST_EXP_LOAD: begin
            cmd.op   = DP_EXP_LOAD;
            state_in = ST_EXP_CHECK;
         end
         ST_EXP_CHECK: begin
            if (stat.iter_zero || stat.w_zero) begin
               state_in = ST_ROUND;
            end else if (stat.exp_neg) begin
               cmd.op   = DP_DIV_INIT;
               state_in = ST_EXP_DIV;
            end else begin
               cmd.op   = DP_TEN_MUL;
               state_in = ST_EXP_NORM;
            end
         end
         ST_EXP_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (stat.div_last) begin
               state_in = ST_EXP_NORM;
            end
         end
         ST_EXP_NORM: begin
            if (stat.w_zero) begin
               state_in = ST_ROUND;
            end else if (stat.w_top) begin
               cmd.op   = DP_ITER_DEC;
               state_in = ST_EXP_CHECK;
            end else begin
               cmd.op = DP_NORM_BE;
            end
         end
         ST_ROUND: begin
            cmd.op   = DP_ROUND;
            state_in = ST_PACK;
         end
         ST_PACK: begin
            cmd.op   = DP_PACK;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_PARSE;
            end
         end
         default: begin
            state_in = ST_PARSE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DSTD_ASSERT_NXT(a_last_stalls_intake, clock, reset, req_valid && req_ready && req_is_last, !req_ready, "intake open after final character")
   `DSTD_ASSERT_NXT(a_emit_when_free, clock, reset, state_ff == ST_EMIT && !rsp_valid_ff, rsp_valid_ff, "result not issued on free slot")
   `DSTD_ASSERT_IMP(a_valid_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_EMIT), "result issued outside emit")

endmodule

### rtl/dstd_dp.sv
// ----------------------------------------------------------------------------
// dstd_dp
// Datapath: character parsing registers, shared divide-by-ten and normalize
// units, binary fraction expansion, rounding and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dstd_dp import dstd_pkg::*; #(
   parameter int MAX_LEN   = 4096,
   parameter int EXP_LIMIT = 511
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [7:0]  req_char_byte,
   output logic [63:0] rsp_value_bits,
   output logic [12:0] rsp_consumed,
   output logic        rsp_status
);

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int EW = $clog2(EXP_LIMIT + 1);

   typedef enum logic [3:0] {
      PH_WS, PH_SIGNED, PH_N, PH_NA, PH_NAN, PH_PAREN, PH_I, PH_IN,
      PH_INT, PH_FRAC, PH_ESTART, PH_ESIGN, PH_EDIG, PH_DONE_NUM,
      PH_DONE_NAN, PH_DONE_INF
   } phase_type;

   // parse state
   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [63:0]        iv_ff, iv_in;
   logic               inr_ff, inr_in;
   logic [15:0]        extra_ff, extra_in;
   logic [63:0]        fv_ff, fv_in;
   logic [63:0]        depth_ff, depth_in;
   logic [15:0]        lz_ff, lz_in;
   logic [EW-1:0]      ev_ff, ev_in;
   logic               eneg_ff, eneg_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      endp_ff, endp_in;

   // build state
   logic [63:0]        w_ff, w_in;
   logic [63:0]        f_ff, f_in;
   logic signed [23:0] be_ff, be_in;
   logic [19:0]        acc_ff, acc_in;
   logic [15:0]        iter_ff, iter_in;
   logic [5:0]         step_ff, step_in;
   logic [3:0]         rem_ff, rem_in;
   logic               ovf_ff, ovf_in;
   logic [51:0]        r_ff, r_in;
   logic [63:0]        res_bits_ff, res_bits_in;
   logic               res_stat_ff, res_stat_in;
   logic [63:0]        out_bits_ff, out_bits_in;
   logic [12:0]        out_cons_ff, out_cons_in;
   logic               out_stat_ff, out_stat_in;

   // character classes
   logic [7:0]         c;
   logic [3:0]         d;
   logic               is_dig, is_sp, is_exp_ch, absorb_en;
   logic [PW-1:0]      p1;
   logic               int_ovf, frac_skip;
   logic [63:0]        iv_x10, fv_x10, depth_x10;
   logic [EW+3:0]      ev_x10;
   logic               do_first, do_int, do_frac;

   // build helpers
   logic [63:0]        half, f_sub, t16;
   logic               f_gt;
   logic [7:0]         dx;
   logic [15:0]        dprod;
   logic [3:0]         qd;
   logic [7:0]         rem_full;
   logic [20:0]        asm_tot;
   logic [63:0]        asm_frac;
   logic [52:0]        r0;
   logic signed [23:0] be1, be1p, nb, ne;
   logic [63:0]        cmp_word;
   logic [51:0]        rr, rs;
   logic [PW+12:0]     endp_wide;

   assign c         = req_char_byte;
   assign d         = 4'(c - 8'h30);
   assign is_dig    = (c >= "0") && (c <= "9");
   assign is_sp     = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   assign is_exp_ch = (c == "e") || (c == "E") || (c == "f") || (c == "F");
   assign absorb_en = cmd.take && (pos_ff < PW'(MAX_LEN));
   assign p1        = pos_ff + PW'(1);

   assign int_ovf   = !inr_ff || (iv_ff > TENTH_MAX) || ((iv_ff == TENTH_MAX) && (d > 4'd5));
   assign frac_skip = (depth_ff > TENTH_MAX) || (fv_ff > TENTH_MAX) ||
                      ((fv_ff == TENTH_MAX) && (d > 4'd5));
   assign iv_x10    = (iv_ff << 3) + (iv_ff << 1) + {60'b0, d};
   assign fv_x10    = (fv_ff << 3) + (fv_ff << 1) + {60'b0, d};
   assign depth_x10 = (depth_ff << 3) + (depth_ff << 1);
   assign ev_x10    = ({4'b0, ev_ff} << 3) + ({4'b0, ev_ff} << 1) + (EW+4)'(d);

   assign half      = depth_ff >> 1;
   assign f_gt      = f_ff > half;
   assign f_sub     = f_gt ? (f_ff - half) : f_ff;
   assign t16       = {4'b0, w_ff[63:4]};

   assign dx        = {rem_ff, w_ff[63:60]};
   assign dprod     = {8'b0, dx} * 16'd205;
   assign qd        = dprod[14:11];
   assign rem_full  = dx - ({4'b0, qd} << 3) - ({4'b0, qd} << 1);

   assign asm_tot   = 21'(be_ff[5:0]) + 21'd1 + {1'b0, acc_ff};
   assign asm_frac  = (asm_tot >= 21'd64) ? 64'b0 : (w_ff >> asm_tot[5:0]);

   assign r0        = {1'b0, w_ff[62:11]} + {52'b0, w_ff[10]};
   assign be1       = be_ff + $signed({23'b0, r0[52]});
   assign be1p      = be1 + 24'sd1022;
   assign cmp_word  = {1'b0, be1p[10:0], r0[51:0]};

   assign nb        = 24'sd0 - be_ff - 24'sd1023;
   assign ne        = be_ff + 24'sd1023;
   assign rr        = {1'b1, r_ff[51:1]};
   assign rs        = (nb >= 24'sd64) ? 52'b0 : (rr >> nb[5:0]);

   assign endp_wide = {13'b0, endp_ff};

   always_comb begin
      stat.need_build   = ((phase_ff == PH_INT) || (phase_ff == PH_FRAC) ||
                           (phase_ff == PH_ESTART) || (phase_ff == PH_ESIGN) ||
                           (phase_ff == PH_EDIG) || (phase_ff == PH_DONE_NUM)) &&
                          ((iv_ff != 64'b0) || (fv_ff != 64'b0));
      stat.int_in_range = inr_ff;
      stat.int_zero     = (iv_ff == 64'b0);
      stat.int_top      = iv_ff[63];
      stat.w_zero       = (w_ff == 64'b0);
      stat.w_top        = w_ff[63];
      stat.iter_zero    = (iter_ff == 16'b0);
      stat.frac_last    = (step_ff == 6'd63);
      stat.div_last     = (step_ff[3:0] == 4'hF);
      stat.exp_neg      = eneg_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      iv_in       = iv_ff;
      inr_in      = inr_ff;
      extra_in    = extra_ff;
      fv_in       = fv_ff;
      depth_in    = depth_ff;
      lz_in       = lz_ff;
      ev_in       = ev_ff;
      eneg_in     = eneg_ff;
      pos_in      = pos_ff;
      endp_in     = endp_ff;
      w_in        = w_ff;
      f_in        = f_ff;
      be_in       = be_ff;
      acc_in      = acc_ff;
      iter_in     = iter_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      ovf_in      = ovf_ff;
      r_in        = r_ff;
      res_bits_in = res_bits_ff;
      res_stat_in = res_stat_ff;
      out_bits_in = out_bits_ff;
      out_cons_in = out_cons_ff;
      out_stat_in = out_stat_ff;
      do_first    = 1'b0;
      do_int      = 1'b0;
      do_frac     = 1'b0;

      if (absorb_en) begin
         pos_in = p1;
         case (phase_ff)
            PH_WS: begin
               if (is_sp) begin
                  endp_in = p1;
               end else begin
                  endp_in = pos_ff;
                  if (c == "-") begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGNED;
                  end else if (c == "+") begin
                     phase_in = PH_SIGNED;
                  end else begin
                     do_first = 1'b1;
                  end
               end
            end
            PH_SIGNED: do_first = 1'b1;
            PH_N:      phase_in = ((c == "a") || (c == "A")) ? PH_NA : PH_DONE_NUM;
            PH_NA: begin
               if ((c == "n") || (c == "N")) begin
                  endp_in  = p1;
                  phase_in = PH_NAN;
               end else begin
                  phase_in = PH_DONE_NUM;
               end
            end
            PH_NAN:    phase_in = (c == "(") ? PH_PAREN : PH_DONE_NAN;
            PH_PAREN: begin
               if (c == ")") begin
                  endp_in  = p1;
                  phase_in = PH_DONE_NAN;
               end
            end
            PH_I:      phase_in = ((c == "n") || (c == "N")) ? PH_IN : PH_DONE_NUM;
            PH_IN: begin
               if ((c == "f") || (c == "F")) begin
                  endp_in  = p1;
                  phase_in = PH_DONE_INF;
               end else begin
                  phase_in = PH_DONE_NUM;
               end
            end
            PH_INT: begin
               if (is_dig) begin
                  do_int  = 1'b1;
                  endp_in = p1;
               end else if (c == ".") begin
                  endp_in  = p1;
                  phase_in = PH_FRAC;
               end else if (is_exp_ch) begin
                  phase_in = PH_ESTART;
               end else begin
                  phase_in = PH_DONE_NUM;
               end
            end
            PH_FRAC: begin
               if (is_dig) begin
                  do_frac = 1'b1;
                  endp_in = p1;
               end else if (is_exp_ch) begin
                  phase_in = PH_ESTART;
               end else begin
                  phase_in = PH_DONE_NUM;
               end
            end
            PH_ESTART, PH_ESIGN, PH_EDIG: begin
               if (is_dig) begin
                  ev_in    = (ev_x10 > (EW+4)'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : ev_x10[EW-1:0];
                  endp_in  = p1;
                  phase_in = PH_EDIG;
               end else if ((phase_ff == PH_ESTART) && ((c == "+") || (c == "-"))) begin
                  eneg_in  = (c == "-");
                  phase_in = PH_ESIGN;
               end else begin
                  if (phase_ff != PH_EDIG) begin
                     eneg_in = 1'b0;
                  end
                  phase_in = PH_DONE_NUM;
               end
            end
            default: begin
            end
         endcase

         if (do_first) begin
            if ((c == "n") || (c == "N")) begin
               phase_in = PH_N;
            end else if ((c == "i") || (c == "I")) begin
               phase_in = PH_I;
            end else if (is_dig) begin
               do_int   = 1'b1;
               endp_in  = p1;
               phase_in = PH_INT;
            end else if (c == ".") begin
               endp_in  = p1;
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE_NUM;
            end
         end

         if (do_int) begin
            if (int_ovf) begin
               inr_in = 1'b0;
               if (extra_ff != 16'hFFFF) begin
                  extra_in = extra_ff + 16'd1;
               end
            end else begin
               iv_in = iv_x10;
            end
         end

         if (do_frac && !frac_skip) begin
            if ((d == 4'd0) && (depth_ff == 64'd1)) begin
               if (lz_ff != 16'hFFFF) begin
                  lz_in = lz_ff + 16'd1;
               end
            end else begin
               fv_in    = fv_x10;
               depth_in = depth_x10;
            end
         end
      end

      case (cmd.op)
         DP_SPECIAL: begin
            res_stat_in = 1'b0;
            case (phase_ff)
               PH_NAN, PH_PAREN, PH_DONE_NAN: res_bits_in = QNAN;
               PH_DONE_INF:                   res_bits_in = neg_ff ? NEG_INF : POS_INF;
               default:                       res_bits_in = 64'b0;
            endcase
         end
         DP_FRAC_INIT: begin
            f_in    = fv_ff;
            w_in    = 64'b0;
            step_in = 6'd0;
            iter_in = lz_ff;
            acc_in  = 20'd0;
         end
         DP_FRAC_STEP: begin
            f_in    = f_sub << 1;
            w_in    = {w_ff[62:0], f_gt};
            step_in = step_ff + 6'd1;
         end
         DP_DIV_INIT: begin
            rem_in  = 4'd0;
            step_in = 6'd0;
         end
         DP_DIV_STEP: begin
            rem_in  = rem_full[3:0];
            w_in    = {w_ff[59:0], qd};
            step_in = step_ff + 6'd1;
         end
         DP_NORM_ACC: begin
            w_in   = w_ff << 1;
            acc_in = acc_ff + 20'd1;
         end
         DP_NORM_BE: begin
            w_in  = w_ff << 1;
            be_in = be_ff - 24'sd1;
         end
         DP_ITER_DEC:   iter_in = iter_ff - 16'd1;
         DP_ZINT_SETUP: be_in = -24'sd1 - $signed({4'b0, acc_ff});
         DP_BE_INIT:    be_in = 24'sd63;
         DP_INT_SHIFT: begin
            iv_in = iv_ff << 1;
            be_in = be_ff - 24'sd1;
         end
         DP_ASSEMBLE:   w_in = iv_ff | asm_frac;
         DP_EXTRA_LOAD: begin
            w_in    = iv_ff;
            iter_in = extra_ff;
         end
         DP_TEN_MUL: begin
            w_in  = (t16 << 3) + (t16 << 1);
            be_in = be_ff + 24'sd4;
         end
         DP_EXP_LOAD: begin
            iter_in         = 16'b0;
            iter_in[EW-1:0] = ev_ff;
         end
         DP_ROUND: begin
            ovf_in = (be_ff >= 24'sd1024) ||
                     ((be1 > 24'sd0) && (cmp_word > ROUND_LIMIT));
            r_in   = r0[51:0];
            be_in  = be1;
         end
         DP_PACK: begin
            if (ovf_ff) begin
               res_bits_in = neg_ff ? NEG_INF : POS_INF;
               res_stat_in = 1'b1;
            end else if (be_ff <= -24'sd1023) begin
               if (rs == 52'b0) begin
                  res_bits_in = {neg_ff, 63'b0};
                  res_stat_in = 1'b1;
               end else begin
                  res_bits_in = {neg_ff, 11'b0, rs};
                  res_stat_in = 1'b0;
               end
            end else begin
               res_bits_in = {neg_ff, ne[10:0], r_ff};
               res_stat_in = 1'b0;
            end
         end
         DP_LOAD_OUT: begin
            out_bits_in = res_bits_ff;
            out_stat_in = res_stat_ff;
            out_cons_in = endp_wide[12:0];
            phase_in    = PH_WS;
            neg_in      = 1'b0;
            iv_in       = 64'b0;
            inr_in      = 1'b1;
            extra_in    = 16'b0;
            fv_in       = 64'b0;
            depth_in    = 64'd1;
            lz_in       = 16'b0;
            ev_in       = '0;
            eneg_in     = 1'b0;
            pos_in      = '0;
            endp_in     = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         neg_ff   <= 1'b0;
         iv_ff    <= 64'b0;
         inr_ff   <= 1'b1;
         extra_ff <= 16'b0;
         fv_ff    <= 64'b0;
         depth_ff <= 64'd1;
         lz_ff    <= 16'b0;
         ev_ff    <= '0;
         eneg_ff  <= 1'b0;
         pos_ff   <= '0;
         endp_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         iv_ff    <= iv_in;
         inr_ff   <= inr_in;
         extra_ff <= extra_in;
         fv_ff    <= fv_in;
         depth_ff <= depth_in;
         lz_ff    <= lz_in;
         ev_ff    <= ev_in;
         eneg_ff  <= eneg_in;
         pos_ff   <= pos_in;
         endp_ff  <= endp_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      f_ff        <= f_in;
      be_ff       <= be_in;
      acc_ff      <= acc_in;
      iter_ff     <= iter_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      ovf_ff      <= ovf_in;
      r_ff        <= r_in;
      res_bits_ff <= res_bits_in;
      res_stat_ff <= res_stat_in;
      out_bits_ff <= out_bits_in;
      out_cons_ff <= out_cons_in;
      out_stat_ff <= out_stat_in;
   end

   assign rsp_value_bits = out_bits_ff;
   assign rsp_consumed   = out_cons_ff;
   assign rsp_status     = out_stat_ff;

   `DSTD_ASSERT_IMP(a_norm_nonzero, clock, reset, cmd.op == DP_NORM_BE || cmd.op == DP_NORM_ACC, w_ff != 64'b0, "normalize on zero word")
   `DSTD_ASSERT_IMP(a_int_shift_nonzero, clock, reset, cmd.op == DP_INT_SHIFT, iv_ff != 64'b0, "integral shift on zero")
   `DSTD_ASSERT_IMP(a_div_rem_range, clock, reset, cmd.op == DP_DIV_STEP, rem_ff < 4'd10, "divide remainder out of range")

endmodule

### rtl/decimal_string_to_double_core.sv
// ----------------------------------------------------------------------------
// decimal_string_to_double_core
// Decimal text to IEEE-754 double, one character per transaction.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                   handshake
//  req      in         req_char_byte, req_is_last                req_valid/req_ready
//  rsp      out        rsp_value_bits, rsp_consumed, rsp_status  rsp_valid/rsp_ready
//
//  Characters: one per cycle while req_ready is high. After the last one the
//  build runs: fraction expansion when the integral part fits, a divide and
//  normalize per fraction leading zero, initial normalization, a multiply and
//  normalize per dropped integral digit and positive exponent step, a divide
//  and normalize per negative exponent step, rounding and packing, using the
//  4-bit-per-cycle divide-by-ten unit and the 1-bit-per-cycle normalizer.
//  Reset clears parse state; intake is held during the build and while a
//  finished result waits for a full output register.
// ----------------------------------------------------------------------------
module decimal_string_to_double_core import dstd_pkg::*; #(
   parameter int MAX_LEN   = 4096,
   parameter int EXP_LIMIT = 511
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value_bits,
   output logic [12:0] rsp_consumed,
   output logic        rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dstd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   dstd_dp #(
      .MAX_LEN   (MAX_LEN),
      .EXP_LIMIT (EXP_LIMIT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_char_byte  (req_char_byte),
      .rsp_value_bits (rsp_value_bits),
      .rsp_consumed   (rsp_consumed),
      .rsp_status     (rsp_status)
   );

endmodule
